@@ hdl/jfdu_pkg.sv @@
package jfdu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_FRAC = 8;

  localparam logic [1:0] OP_BUSH_TRANS = 2'd0;
  localparam logic [1:0] OP_BUSH_ROT   = 2'd1;
  localparam logic [1:0] OP_SPIN       = 2'd2;
  localparam logic [1:0] OP_TILT       = 2'd3;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_TRANS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_TRANS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_ROT      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_ROT     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_UPPER      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LOWER      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_SPEED_UP   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_SPEED_DOWN = 4'd7;

  localparam logic [31:0]        RST_SPRING_TRANS    = 32'd281600000;
  localparam logic [31:0]        RST_DAMPING_TRANS   = 32'd281600;
  localparam logic [31:0]        RST_SPRING_ROT      = 32'd640000;
  localparam logic [31:0]        RST_DAMPING_ROT     = 32'd640;
  localparam logic signed [31:0] RST_TILT_UPPER      = 32'sd88474;
  localparam logic signed [31:0] RST_TILT_LOWER      = -32'sd45875;
  localparam logic signed [31:0] RST_TILT_SPEED_UP   = 32'sd65536;
  localparam logic signed [31:0] RST_TILT_SPEED_DOWN = -32'sd65536;

  typedef struct packed {
    logic [1:0]        opcode;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
  } in_t;

  typedef struct packed {
    logic signed [47:0] force_res;
    logic               sweep_up;
  } out_t;

  typedef struct packed {
    logic [31:0]        spring_trans;
    logic [31:0]        damping_trans;
    logic [31:0]        spring_rot;
    logic [31:0]        damping_rot;
    logic signed [31:0] tilt_upper;
    logic signed [31:0] tilt_lower;
    logic signed [31:0] tilt_speed_up;
    logic signed [31:0] tilt_speed_down;
  } cfg_t;

  // partial results between the multiply stage and the result stage
  typedef struct packed {
    logic               is_bush;
    logic signed [63:0] prod_k;
    logic signed [63:0] prod_d;
    logic signed [32:0] err_target;
    logic signed [32:0] err_delta;
    logic               sweep_up;
  } st_t;

endpackage

@@ hdl/joint_force_drive_unit.sv @@
// an accepted input transaction is registered in the middle stage, then in the output stage, before out_valid
// throughput: one transaction per cycle while the output is not stalled, set by the multiply stage followed
// by the shift, sum and saturate stage, each closed by a register
// reset: synchronous, active high; registers return to their default gains and
// bounds, motor velocity history clears, the tilt flag sets, the pipe empties
module joint_force_drive_unit #(
  parameter int FRAC_BITS = jfdu_pkg::FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jfdu_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jfdu_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jfdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  jfdu_pkg::cfg_t cfg;
  jfdu_pkg::st_t  st;
  logic           st_valid;
  logic           st_ready;

  jfdu_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jfdu_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st       (st)
  );

  jfdu_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .st_valid  (st_valid),
    .st_ready  (st_ready),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // input stalls only when both stages hold a transaction and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (st_valid && out_valid && out_stall))
    else $error("input stalled while pipe has room");

  // a held middle stage keeps its transaction
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (st_valid && !st_ready) |=> st_valid)
    else $error("middle stage transaction lost");

  // draining with an empty middle stage leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !st_valid) |=> !out_valid)
    else $error("result invented");

  // every accepted input occupies the middle stage next cycle
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> st_valid)
    else $error("accepted transaction dropped");

endmodule

@@ hdl/jfdu_regs.sv @@
module jfdu_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jfdu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output jfdu_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spring_trans    <= jfdu_pkg::RST_SPRING_TRANS;
      cfg.damping_trans   <= jfdu_pkg::RST_DAMPING_TRANS;
      cfg.spring_rot      <= jfdu_pkg::RST_SPRING_ROT;
      cfg.damping_rot     <= jfdu_pkg::RST_DAMPING_ROT;
      cfg.tilt_upper      <= jfdu_pkg::RST_TILT_UPPER;
      cfg.tilt_lower      <= jfdu_pkg::RST_TILT_LOWER;
      cfg.tilt_speed_up   <= jfdu_pkg::RST_TILT_SPEED_UP;
      cfg.tilt_speed_down <= jfdu_pkg::RST_TILT_SPEED_DOWN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jfdu_pkg::REG_SPRING_TRANS:    cfg.spring_trans    <= cfg_data;
        jfdu_pkg::REG_DAMPING_TRANS:   cfg.damping_trans   <= cfg_data;
        jfdu_pkg::REG_SPRING_ROT:      cfg.spring_rot      <= cfg_data;
        jfdu_pkg::REG_DAMPING_ROT:     cfg.damping_rot     <= cfg_data;
        jfdu_pkg::REG_TILT_UPPER:      cfg.tilt_upper      <= signed'(cfg_data);
        jfdu_pkg::REG_TILT_LOWER:      cfg.tilt_lower      <= signed'(cfg_data);
        jfdu_pkg::REG_TILT_SPEED_UP:   cfg.tilt_speed_up   <= signed'(cfg_data);
        jfdu_pkg::REG_TILT_SPEED_DOWN: cfg.tilt_speed_down <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/jfdu_front.sv @@
module jfdu_front #(
  parameter int FRAC_BITS = jfdu_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  jfdu_pkg::in_t  in_data,
  input  jfdu_pkg::cfg_t cfg,
  output logic           st_valid,
  input  logic           st_ready,
  output jfdu_pkg::st_t  st
);

  localparam logic signed [31:0] SPIN_TARGET = 32'sd1 <<< FRAC_BITS;

  logic signed [31:0] spin_last_velocity;
  logic signed [31:0] tilt_last_velocity;
  logic               tilt_going_up;

  logic               accept;
  logic               flag_tilt;
  logic [31:0]        gain_k;
  logic [31:0]        gain_d;
  logic signed [32:0] gain_k_s;
  logic signed [32:0] gain_d_s;
  logic signed [31:0] target;
  logic signed [31:0] prev_velocity;
  logic               is_tilt;
  jfdu_pkg::st_t      st_next;

  assign in_stall = st_valid && !st_ready;
  assign accept   = in_valid && !in_stall;
  assign is_tilt  = (in_data.opcode == jfdu_pkg::OP_TILT);

  always_comb begin
    // hysteresis: upper bound wins over lower bound
    if (in_data.position > cfg.tilt_upper) begin
      flag_tilt = 1'b0;
    end else if (in_data.position < cfg.tilt_lower) begin
      flag_tilt = 1'b1;
    end else begin
      flag_tilt = tilt_going_up;
    end

    gain_k   = (in_data.opcode == jfdu_pkg::OP_BUSH_TRANS) ? cfg.spring_trans : cfg.spring_rot;
    gain_d   = (in_data.opcode == jfdu_pkg::OP_BUSH_TRANS) ? cfg.damping_trans : cfg.damping_rot;
    gain_k_s = signed'({1'b0, gain_k});
    gain_d_s = signed'({1'b0, gain_d});

    if (is_tilt) begin
      target        = flag_tilt ? cfg.tilt_speed_up : cfg.tilt_speed_down;
      prev_velocity = tilt_last_velocity;
    end else begin
      target        = SPIN_TARGET;
      prev_velocity = spin_last_velocity;
    end

    st_next.is_bush    = (in_data.opcode == jfdu_pkg::OP_BUSH_TRANS) ||
                         (in_data.opcode == jfdu_pkg::OP_BUSH_ROT);
    st_next.prod_k     = 64'(gain_k_s) * 64'(in_data.position);
    st_next.prod_d     = 64'(gain_d_s) * 64'(in_data.velocity);
    st_next.err_target = 33'(in_data.velocity) - 33'(target);
    st_next.err_delta  = 33'(in_data.velocity) - 33'(prev_velocity);
    st_next.sweep_up   = is_tilt ? flag_tilt : tilt_going_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid           <= 1'b0;
      spin_last_velocity <= '0;
      tilt_last_velocity <= '0;
      tilt_going_up      <= 1'b1;
    end else begin
      if (accept) begin
        st_valid <= 1'b1;
      end else if (st_ready) begin
        st_valid <= 1'b0;
      end
      if (accept && in_data.opcode == jfdu_pkg::OP_SPIN) begin
        spin_last_velocity <= in_data.velocity;
      end
      if (accept && is_tilt) begin
        tilt_last_velocity <= in_data.velocity;
        tilt_going_up      <= flag_tilt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st <= st_next;
    end
  end

endmodule

@@ hdl/jfdu_back.sv @@
module jfdu_back #(
  parameter int FRAC_BITS = jfdu_pkg::FRAC_BITS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           st_valid,
  output logic           st_ready,
  input  jfdu_pkg::st_t  st,
  output logic           out_valid,
  input  logic           out_stall,
  output jfdu_pkg::out_t out_data
);

  localparam logic signed [65:0] FORCE_MAX = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] FORCE_MIN = -FORCE_MAX - 66'sd1;
  localparam logic signed [43:0] TQ_LIM    = 44'sd200 <<< FRAC_BITS;

  logic signed [63:0] term_k;
  logic signed [63:0] term_d;
  logic signed [65:0] bush_sum;
  logic signed [65:0] bush_neg;
  logic signed [47:0] bush_force;
  logic signed [43:0] tq;
  logic signed [43:0] tq_clamped;
  jfdu_pkg::out_t     res;

  assign st_ready = !out_valid || !out_stall;

  always_comb begin
    // arithmetic shift gives floor rounding of the Q24.8 gain products
    term_k   = st.prod_k >>> jfdu_pkg::GAIN_FRAC;
    term_d   = st.prod_d >>> jfdu_pkg::GAIN_FRAC;
    bush_sum = 66'(term_k) + 66'(term_d);
    bush_neg = -bush_sum;
    if (bush_neg > FORCE_MAX) begin
      bush_force = FORCE_MAX[47:0];
    end else if (bush_neg < FORCE_MIN) begin
      bush_force = FORCE_MIN[47:0];
    end else begin
      bush_force = bush_neg[47:0];
    end

    tq = -(44'(st.err_target) * 44'sd100) - (44'(st.err_delta) * 44'sd200);
    if (tq > TQ_LIM) begin
      tq_clamped = TQ_LIM;
    end else if (tq < -TQ_LIM) begin
      tq_clamped = -TQ_LIM;
    end else begin
      tq_clamped = tq;
    end

    res.force_res = st.is_bush ? bush_force : 48'(tq_clamped);
    res.sweep_up  = st.sweep_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st_ready) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready && st_valid) begin
      out_data <= res;
    end
  end

endmodule

@@ tb/sv/joint_force_drive_unit_tb.sv @@
module joint_force_drive_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     LATENCY     = 2;
  localparam longint FORCE_HI    = 64'sd140737488355327;
  localparam longint FORCE_LO    = -64'sd140737488355328;
  localparam longint WORD_HI     = 64'sd2147483647;
  localparam longint WORD_LO     = -64'sd2147483648;
  localparam longint SPIN_TARGET = 64'sd1 <<< jfdu_pkg::FRAC_BITS;
  localparam logic [jfdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 4'd8;
  localparam logic [jfdu_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 4'd15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  jfdu_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  jfdu_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [jfdu_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // predictor state
  jfdu_pkg::cfg_t drive_cfg;
  longint spin_prev_vel;
  longint tilt_prev_vel;
  bit     tilt_up_flag;

  jfdu_pkg::out_t expected_forces[$];
  int   fail_count = 0;

  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;

  joint_force_drive_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void reset_drive_model();
    drive_cfg.spring_trans    = jfdu_pkg::RST_SPRING_TRANS;
    drive_cfg.damping_trans   = jfdu_pkg::RST_DAMPING_TRANS;
    drive_cfg.spring_rot      = jfdu_pkg::RST_SPRING_ROT;
    drive_cfg.damping_rot     = jfdu_pkg::RST_DAMPING_ROT;
    drive_cfg.tilt_upper      = jfdu_pkg::RST_TILT_UPPER;
    drive_cfg.tilt_lower      = jfdu_pkg::RST_TILT_LOWER;
    drive_cfg.tilt_speed_up   = jfdu_pkg::RST_TILT_SPEED_UP;
    drive_cfg.tilt_speed_down = jfdu_pkg::RST_TILT_SPEED_DOWN;
    spin_prev_vel = 0;
    tilt_prev_vel = 0;
    tilt_up_flag  = 1'b1;
  endfunction

  function automatic void apply_reg(input logic [jfdu_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [31:0] val);
    case (idx)
      jfdu_pkg::REG_SPRING_TRANS:    drive_cfg.spring_trans = val;
      jfdu_pkg::REG_DAMPING_TRANS:   drive_cfg.damping_trans = val;
      jfdu_pkg::REG_SPRING_ROT:      drive_cfg.spring_rot = val;
      jfdu_pkg::REG_DAMPING_ROT:     drive_cfg.damping_rot = val;
      jfdu_pkg::REG_TILT_UPPER:      drive_cfg.tilt_upper = val;
      jfdu_pkg::REG_TILT_LOWER:      drive_cfg.tilt_lower = val;
      jfdu_pkg::REG_TILT_SPEED_UP:   drive_cfg.tilt_speed_up = val;
      jfdu_pkg::REG_TILT_SPEED_DOWN: drive_cfg.tilt_speed_down = val;
      default: ;
    endcase
  endfunction

  function automatic longint motor_torque(input longint v, input longint v_prev,
                                          input longint target);
    longint lim, tq;
    lim = 64'sd200 <<< jfdu_pkg::FRAC_BITS;
    tq = -(v - target) * 100 - (v - v_prev) * 200;
    if (tq > lim) tq = lim;
    if (tq < -lim) tq = -lim;
    return tq;
  endfunction

  function automatic jfdu_pkg::out_t drive_force(input jfdu_pkg::in_t s);
    jfdu_pkg::out_t r;
    longint q, dq, gk, gd, f;
    q = s.position;
    dq = s.velocity;
    f = 0;
    case (s.opcode)
      jfdu_pkg::OP_BUSH_TRANS, jfdu_pkg::OP_BUSH_ROT: begin
        gk = (s.opcode == jfdu_pkg::OP_BUSH_TRANS) ? drive_cfg.spring_trans
                                                   : drive_cfg.spring_rot;
        gd = (s.opcode == jfdu_pkg::OP_BUSH_TRANS) ? drive_cfg.damping_trans
                                                   : drive_cfg.damping_rot;
        // arithmetic shift floors toward minus infinity
        f = -(((gk * q) >>> jfdu_pkg::GAIN_FRAC) + ((gd * dq) >>> jfdu_pkg::GAIN_FRAC));
        if (f > FORCE_HI) f = FORCE_HI;
        else if (f < FORCE_LO) f = FORCE_LO;
      end
      jfdu_pkg::OP_SPIN: begin
        f = motor_torque(dq, spin_prev_vel, SPIN_TARGET);
        spin_prev_vel = dq;
      end
      jfdu_pkg::OP_TILT: begin
        // flag moves before the torque uses it
        if (q > longint'(drive_cfg.tilt_upper)) tilt_up_flag = 1'b0;
        else if (q < longint'(drive_cfg.tilt_lower)) tilt_up_flag = 1'b1;
        f = motor_torque(dq, tilt_prev_vel, tilt_up_flag ? longint'(drive_cfg.tilt_speed_up)
                                                          : longint'(drive_cfg.tilt_speed_down));
        tilt_prev_vel = dq;
      end
      default: ;
    endcase
    r.force_res = f[47:0];
    r.sweep_up = tilt_up_flag;
    return r;
  endfunction

  function automatic void log_mismatch(input string what, input longint want, input longint got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin : input_monitor
    if (!rst && in_valid && !in_stall)
      expected_forces = {expected_forces, drive_force(in_data)};
  end

  always @(posedge clk) begin : cfg_monitor
    if (!rst && cfg_valid && cfg_ready)
      apply_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin : result_checker
    jfdu_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_forces.size() == 0) begin
        log_mismatch("unexpected result transaction", 0, longint'(out_data.force_res));
      end else begin
        want = expected_forces.pop_front();
        if (out_data.force_res !== want.force_res)
          log_mismatch("force_res", longint'(want.force_res), longint'(out_data.force_res));
        if (out_data.sweep_up !== want.sweep_up)
          log_mismatch("sweep_up", longint'(want.sweep_up), longint'(out_data.sweep_up));
      end
    end
  end

  // receiver side: random stall bursts, or one long hold when asked
  initial begin : receiver
    int burst;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        burst = hold_len;
        hold_len = 0;
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_sample(input jfdu_pkg::in_t s);
    int gap;
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] pos, input logic [31:0] vel);
    jfdu_pkg::in_t s;
    s.opcode = op;
    s.position = pos;
    s.velocity = vel;
    send_sample(s);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the monitor record a transaction accepted at this edge
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes, lowered by the caller
  task automatic write_reg(input logic [jfdu_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] small_word(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v;
  endfunction

  function automatic logic [31:0] clamp_word(input longint v);
    if (v > WORD_HI) return WORD_HI[31:0];
    if (v < WORD_LO) return WORD_LO[31:0];
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return small_word(1 << 18);
    endcase
  endfunction

  function automatic logic [31:0] rand_reg_value(input logic [jfdu_pkg::CFG_IDX_W-1:0] idx);
    if (idx <= jfdu_pkg::REG_DAMPING_ROT) begin
      case ($urandom_range(0, 5))
        0: return 32'h0;
        1: return 32'hffff_ffff;
        2, 3: return $urandom_range(0, 1 << 20);
        4: return $urandom;
        default: return $urandom_range(0, 1 << 12);
      endcase
    end
    case ($urandom_range(0, 6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return small_word(4 << jfdu_pkg::FRAC_BITS);
    endcase
  endfunction

  function automatic jfdu_pkg::in_t rand_sample();
    jfdu_pkg::in_t s;
    s.opcode = 2'($urandom_range(jfdu_pkg::OP_BUSH_TRANS, jfdu_pkg::OP_TILT));
    s.position = rand_word();
    s.velocity = rand_word();
    if (s.opcode == jfdu_pkg::OP_SPIN || s.opcode == jfdu_pkg::OP_TILT) begin
      if ($urandom_range(0, 9) < 7) s.velocity = small_word(1 << 17);
      // park the tilt position next to a bound now and then
      if (s.opcode == jfdu_pkg::OP_TILT && $urandom_range(0, 1))
        s.position = clamp_word(($urandom_range(0, 1) ? longint'(drive_cfg.tilt_upper)
                                                       : longint'(drive_cfg.tilt_lower))
                                + $signed(small_word(4)));
    end
    return s;
  endfunction

  // tilt run that walks across both bounds and back
  task automatic send_tilt_sweep(output int count);
    longint lo, hi, span, margin, p;
    int n, t;
    lo = drive_cfg.tilt_lower;
    hi = drive_cfg.tilt_upper;
    if (lo > hi) begin
      p = lo;
      lo = hi;
      hi = p;
    end
    span = hi - lo;
    margin = span / 4 + 16;
    n = $urandom_range(4, 10);
    count = 0;
    for (int j = 0; j <= 2 * n; j++) begin
      t = (j <= n) ? j : 2 * n - j;
      p = lo - margin + ((span + 2 * margin) * t) / n + $signed(small_word(8));
      send_item(jfdu_pkg::OP_TILT, clamp_word(p), small_word(1 << 16));
      count++;
    end
  endtask

  task automatic load_random_regs();
    wait_idle();
    for (int i = jfdu_pkg::REG_SPRING_TRANS; i <= jfdu_pkg::REG_TILT_SPEED_DOWN; i++)
      write_reg(jfdu_pkg::CFG_IDX_W'(i), rand_reg_value(jfdu_pkg::CFG_IDX_W'(i)));
    if ($urandom_range(0, 1))
      write_reg(jfdu_pkg::CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_bush_extremes();
    send_gap_pct = 25;
    stall_pct = 25;
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h0, 32'h0);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h8000_0000, 32'h8000_0000);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h7fff_ffff, 32'h8000_0000);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'hffff_ffff, 32'hffff_ffff);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h1, 32'h1);
    send_item(jfdu_pkg::OP_BUSH_ROT, 32'h8000_0000, 32'h7fff_ffff);
    send_item(jfdu_pkg::OP_BUSH_ROT, 32'hffff_ffff, 32'h1);
    send_item(jfdu_pkg::OP_BUSH_ROT, 32'h0001_2345, 32'hffff_e57b);
  endtask

  task automatic test_motor_modes();
    send_item(jfdu_pkg::OP_SPIN, 32'h0, 32'h0001_0000);
    send_item(jfdu_pkg::OP_SPIN, 32'h0, 32'h0001_0000);
    send_item(jfdu_pkg::OP_SPIN, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(jfdu_pkg::OP_SPIN, 32'h8000_0000, 32'h8000_0000);
    send_item(jfdu_pkg::OP_TILT, 32'h0, 32'h0000_8000);
    // equal to a bound holds the flag
    send_item(jfdu_pkg::OP_TILT, jfdu_pkg::RST_TILT_UPPER, 32'h0000_8000);
    send_item(jfdu_pkg::OP_TILT, jfdu_pkg::RST_TILT_UPPER + 1, 32'hffff_0000);
    send_item(jfdu_pkg::OP_BUSH_ROT, 32'h0, 32'h0);
    send_item(jfdu_pkg::OP_TILT, jfdu_pkg::RST_TILT_LOWER, 32'hffff_0000);
    send_item(jfdu_pkg::OP_TILT, jfdu_pkg::RST_TILT_LOWER - 1, 32'h0001_0000);
    send_item(jfdu_pkg::OP_SPIN, 32'h0, 32'h0000_f000);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_reg(jfdu_pkg::REG_SPRING_TRANS, 32'hffff_ffff);
    write_reg(jfdu_pkg::REG_DAMPING_TRANS, 32'hffff_ffff);
    write_reg(jfdu_pkg::REG_SPRING_ROT, 32'h0);
    write_reg(jfdu_pkg::REG_DAMPING_ROT, 32'h0);
    // bounds swapped on purpose
    write_reg(jfdu_pkg::REG_TILT_UPPER, 32'h8000_0000);
    write_reg(jfdu_pkg::REG_TILT_LOWER, 32'h7fff_ffff);
    write_reg(jfdu_pkg::REG_TILT_SPEED_UP, 32'h7fff_ffff);
    write_reg(jfdu_pkg::REG_TILT_SPEED_DOWN, 32'h8000_0000);
    // out-of-range indexes must not alias onto real registers
    write_reg(REG_UNUSED_FIRST, 32'h0);
    write_reg(REG_UNUSED_LAST, 32'hdead_beef);
    cfg_valid <= 1'b0;
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h8000_0000, 32'h8000_0000);
    send_item(jfdu_pkg::OP_BUSH_TRANS, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(jfdu_pkg::OP_BUSH_ROT, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(jfdu_pkg::OP_TILT, 32'h8000_0000, 32'h0);
    send_item(jfdu_pkg::OP_TILT, 32'h0, 32'h0);
    send_item(jfdu_pkg::OP_SPIN, 32'h0, 32'h0);
  endtask

  task automatic test_input_backpressure();
    send_gap_pct = 0;
    stall_pct = 0;
    hold_len = 40;
    repeat (40) send_sample(rand_sample());
  endtask

  task automatic test_random_phases();
    int sent, run;
    for (int phase = 0; phase < 6; phase++) begin
      load_random_regs();
      send_gap_pct = (phase % 3 == 0) ? 0 : 15 + 10 * (phase % 3);
      stall_pct = (phase % 3 == 0) ? 0 : 40 - 10 * (phase % 3);
      sent = 0;
      while (sent < 250) begin
        if ($urandom_range(0, 4) == 0) begin
          send_tilt_sweep(run);
          sent += run;
        end else begin
          send_sample(rand_sample());
          sent++;
        end
      end
    end
  endtask

  task automatic test_quiet_finish();
    load_random_regs();
    send_gap_pct = 0;
    stall_pct = 0;
    repeat (60) send_sample(rand_sample());
  endtask

  initial begin
    reset_drive_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_bush_extremes();
    test_motor_modes();
    test_register_extremes();
    test_input_backpressure();
    test_random_phases();
    test_quiet_finish();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule
